[src/wear_leveled_ring_counter_macros.svh]
// assertion macros for the wear-leveled ring counter
// used by the top level only; expects clk and rst in the including scope
`ifndef WEAR_LEVELED_RING_COUNTER_MACROS_SVH
`define WEAR_LEVELED_RING_COUNTER_MACROS_SVH

// property checked at every edge outside reset
`define WLRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WLRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/wlrc_pkg.sv]
// shared types and constants for the wear-leveled ring counter
// no dependencies; used by wlrc_ctrl, wlrc_dp and the top level
`default_nettype none

package wlrc_pkg;

  localparam logic [1:0] CMD_QUERY   = 2'd0;
  localparam logic [1:0] CMD_SET     = 2'd1;
  localparam logic [1:0] CMD_RECOVER = 2'd2;
  localparam logic [1:0] CMD_ERASE   = 2'd3;

  localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ1,
    ST_READ2,
    ST_RC_LAST,
    ST_RC_PREV,
    ST_RC_ISSUE,
    ST_RC_CMP,
    ST_ERASE,
    ST_FIN_ISSUE,
    ST_FIN_READ,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_NEXT,
    RD_LAST,
    RD_SCAN
  } rd_sel_t;

  typedef struct packed {
    logic    take;
    rd_sel_t rd_sel;
    logic    scan_clr;
    logic    scan_inc;
    logic    prev_load;
    logic    ptr_next;
    logic    ptr_found;
    logic    erase_we;
    logic    wr_cond;
    logic    set_reject;
    logic    set_written;
    logic    res_from_rd;
    logic    res_from_val;
    logic    out_load;
  } ctrl_t;

  typedef struct packed {
    logic lt;
    logic gt;
    logic found;
    logic scan_last;
  } stat_t;

endpackage

`default_nettype wire

[src/wlrc_ctrl.sv]
// controller state machine for the wear-leveled ring counter
// depends on wlrc_pkg; drives wlrc_dp through ctrl_t, reads stat_t
`default_nettype none

module wlrc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     command,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire wlrc_pkg::stat_t st,
  output wlrc_pkg::ctrl_t     ctrl
);

  wlrc_pkg::state_t state, state_next;
  logic [1:0]       cmd_q;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wlrc_pkg::ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q <= command;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctrl       = '0;
    ctrl.rd_sel = wlrc_pkg::RD_PTR;
    case (state)
      wlrc_pkg::ST_INIT: begin
        // clearing pass after reset, one cell a cycle
        ctrl.erase_we = 1'b1;
        ctrl.scan_inc = 1'b1;
        if (st.scan_last) begin
          ctrl.scan_clr = 1'b1;
          state_next    = wlrc_pkg::ST_IDLE;
        end
      end
      wlrc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.take     = 1'b1;
          ctrl.scan_clr = 1'b1;
          case (command)
            wlrc_pkg::CMD_QUERY:   state_next = wlrc_pkg::ST_READ1;
            wlrc_pkg::CMD_SET:     state_next = wlrc_pkg::ST_READ1;
            wlrc_pkg::CMD_RECOVER: state_next = wlrc_pkg::ST_RC_LAST;
            wlrc_pkg::CMD_ERASE:   state_next = wlrc_pkg::ST_ERASE;
            default:               state_next = wlrc_pkg::ST_READ1;
          endcase
        end
      end
      wlrc_pkg::ST_READ1: begin
        if (cmd_q == wlrc_pkg::CMD_SET && st.lt) begin
          ctrl.rd_sel = wlrc_pkg::RD_NEXT;
          state_next  = wlrc_pkg::ST_READ2;
        end else begin
          ctrl.res_from_rd = 1'b1;
          ctrl.set_reject  = (cmd_q == wlrc_pkg::CMD_SET) && st.gt;
          state_next       = wlrc_pkg::ST_DONE;
        end
      end
      wlrc_pkg::ST_READ2: begin
        // advance and write the next cell unless it already holds the value
        ctrl.wr_cond      = 1'b1;
        ctrl.ptr_next     = 1'b1;
        ctrl.res_from_val = 1'b1;
        state_next        = wlrc_pkg::ST_DONE;
      end
      wlrc_pkg::ST_RC_LAST: begin
        ctrl.rd_sel = wlrc_pkg::RD_LAST;
        state_next  = wlrc_pkg::ST_RC_PREV;
      end
      wlrc_pkg::ST_RC_PREV: begin
        ctrl.prev_load = 1'b1;
        ctrl.rd_sel    = wlrc_pkg::RD_SCAN;
        state_next     = wlrc_pkg::ST_RC_CMP;
      end
      wlrc_pkg::ST_RC_ISSUE: begin
        ctrl.rd_sel = wlrc_pkg::RD_SCAN;
        state_next  = wlrc_pkg::ST_RC_CMP;
      end
      wlrc_pkg::ST_RC_CMP: begin
        if (st.found) begin
          ctrl.ptr_found = 1'b1;
          state_next     = wlrc_pkg::ST_FIN_ISSUE;
        end else if (st.scan_last) begin
          state_next = wlrc_pkg::ST_FIN_ISSUE;
        end else begin
          ctrl.prev_load = 1'b1;
          ctrl.scan_inc  = 1'b1;
          state_next     = wlrc_pkg::ST_RC_ISSUE;
        end
      end
      wlrc_pkg::ST_ERASE: begin
        ctrl.erase_we = 1'b1;
        ctrl.scan_inc = 1'b1;
        if (st.scan_last) begin
          ctrl.scan_clr    = 1'b1;
          ctrl.set_written = 1'b1;
          state_next       = wlrc_pkg::ST_FIN_ISSUE;
        end
      end
      wlrc_pkg::ST_FIN_ISSUE: begin
        ctrl.rd_sel = wlrc_pkg::RD_PTR;
        state_next  = wlrc_pkg::ST_FIN_READ;
      end
      wlrc_pkg::ST_FIN_READ: begin
        ctrl.res_from_rd = 1'b1;
        state_next       = wlrc_pkg::ST_DONE;
      end
      wlrc_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          ctrl.out_load = 1'b1;
          state_next    = wlrc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wlrc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ctrl.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

`default_nettype wire

[src/wlrc_dp.sv]
// datapath of the wear-leveled ring counter: cell memory, pointer, scan, result
// depends on wlrc_pkg; commanded by wlrc_ctrl
`default_nettype none

module wlrc_dp #(
  parameter int NUM_CELLS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [31:0]     new_value,
  input  wire wlrc_pkg::ctrl_t ctrl,
  output wlrc_pkg::stat_t      st,
  output logic [31:0]          current_value,
  output logic [3:0]           slot_index,
  output logic                 accepted,
  output logic                 cell_written
);

  localparam int PW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam logic [PW-1:0] LAST = PW'(NUM_CELLS - 1);

  logic [31:0]   mem [NUM_CELLS];
  logic [31:0]   rdata;
  logic [PW-1:0] raddr;
  logic [PW-1:0] waddr;
  logic [31:0]   wdata;
  logic          we;

  logic [PW-1:0] ptr;
  logic [PW-1:0] nptr;
  logic [PW-1:0] scan;
  logic [31:0]   val;
  logic [31:0]   prev;
  logic [31:0]   rd_val;
  logic [31:0]   val_rd;
  logic          differ;

  logic [31:0]   res_value;
  logic          res_acc;
  logic          res_wr;

  // erased cells read as zero
  assign rd_val = (rdata == wlrc_pkg::ERASED_WORD) ? 32'd0 : rdata;
  assign val_rd = (val == wlrc_pkg::ERASED_WORD) ? 32'd0 : val;
  assign nptr   = (ptr == LAST) ? '0 : ptr + 1'b1;
  assign differ = (rd_val != val);

  always_comb begin
    case (ctrl.rd_sel)
      wlrc_pkg::RD_PTR:  raddr = ptr;
      wlrc_pkg::RD_NEXT: raddr = nptr;
      wlrc_pkg::RD_LAST: raddr = LAST;
      wlrc_pkg::RD_SCAN: raddr = scan;
      default:           raddr = ptr;
    endcase
  end

  assign we    = ctrl.erase_we || (ctrl.wr_cond && differ);
  assign waddr = ctrl.erase_we ? scan : nptr;
  assign wdata = ctrl.erase_we ? wlrc_pkg::ERASED_WORD : val;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign st.lt        = rd_val < val;
  assign st.gt        = rd_val > val;
  assign st.found     = prev >= rd_val;
  assign st.scan_last = (scan == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      scan <= '0;
    end else begin
      if (ctrl.ptr_next) begin
        ptr <= nptr;
      end else if (ctrl.ptr_found) begin
        // point at the predecessor of the first non-increasing cell
        ptr <= (scan == '0) ? LAST : scan - 1'b1;
      end
      if (ctrl.scan_clr) begin
        scan <= '0;
      end else if (ctrl.scan_inc) begin
        scan <= scan + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      val     <= new_value;
      res_acc <= 1'b1;
      res_wr  <= 1'b0;
    end else begin
      if (ctrl.set_reject) begin
        res_acc <= 1'b0;
      end
      if (ctrl.set_written || (ctrl.wr_cond && differ)) begin
        res_wr <= 1'b1;
      end
    end
    if (ctrl.prev_load) begin
      prev <= rd_val;
    end
    if (ctrl.res_from_rd) begin
      res_value <= rd_val;
    end else if (ctrl.res_from_val) begin
      res_value <= val_rd;
    end
    if (ctrl.out_load) begin
      current_value <= res_value;
      slot_index    <= 4'(ptr);
      accepted      <= res_acc;
      cell_written  <= res_wr;
    end
  end

endmodule

`default_nettype wire

[src/wear_leveled_ring_counter.sv]
// top level of the wear-leveled ring counter: controller plus datapath
// depends on wlrc_pkg, wlrc_ctrl, wlrc_dp and wear_leveled_ring_counter_macros.svh
//
// channel   handshake             payload
// in        in_valid / in_ready   command, new_value
// out       out_valid / out_ready current_value, slot_index, accepted, cell_written
//
// one item at a time; in_ready returns once the item's steps are done, one memory read a step:
//   query or rejected/equal set reads the pointer cell, larger set also reads the next cell,
//   erase clears every cell first, recover scans with an issue and a compare step per cell (single read port)
// after reset a clearing pass writes all ones to every cell, with in_ready low
// a finished result waits in the output register while the next item is taken;
// the block holds in its done state only when a second result would overwrite the first
`default_nettype none
`include "wear_leveled_ring_counter_macros.svh"

module wear_leveled_ring_counter #(
  parameter int NUM_CELLS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] new_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      current_value,
  output logic [3:0]       slot_index,
  output logic             accepted,
  output logic             cell_written
);

  wlrc_pkg::ctrl_t ctrl;
  wlrc_pkg::stat_t st;

  wlrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .ctrl      (ctrl)
  );

  wlrc_dp #(
    .NUM_CELLS (NUM_CELLS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .new_value     (new_value),
    .ctrl          (ctrl),
    .st            (st),
    .current_value (current_value),
    .slot_index    (slot_index),
    .accepted      (accepted),
    .cell_written  (cell_written)
  );

  `WLRC_ASSERT(a_no_write_when_ready, in_ready |-> !(ctrl.erase_we || ctrl.wr_cond), "cell write while taking items")
  `WLRC_ASSERT(a_no_result_overwrite, ctrl.out_load |-> (!out_valid || out_ready), "result overwritten before taken")
  `WLRC_ASSERT_NEXT(a_one_item_at_a_time, in_valid && in_ready, !in_ready, "second item taken while busy")
  `WLRC_ASSERT_NEXT(a_load_sets_valid, ctrl.out_load, out_valid, "loaded result not shown")

endmodule

`default_nettype wire
